[hw/rtl/nkr_pkg.sv]
// Package: item types, register codes and queue sizing for the nearest-K radius select.
package nkr_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [1:0] REG_ORIGIN_X     = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y     = 2'd1;
	localparam logic [1:0] REG_RANGE_RADIUS = 2'd2;

	typedef struct packed {
		logic [5:0]         point_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic               active;
		logic               end_of_set;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  picked_index;
		logic [32:0] distance_sq;
		logic [1:0]  rank;
		logic        found;
		logic        last_pick;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic [15:0]        range_radius;
	} cfg_t;

	// classified point handed from front to back
	typedef struct packed {
		logic [5:0]  index;
		logic [32:0] dsq;
		logic        keep;
		logic        last;
	} job_t;

endpackage

[hw/rtl/nearest_k_within_radius_select.sv]
// Top level: APB register file, front pipeline, job queue and selection back end.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------
//  in      | input     | in_valid / in_ready    | in_data  (in_item_t)
//  out     | output    | out_valid / out_ready  | out_data (out_item_t)
//  apb     | input     | psel/penable/pwrite    | paddr, pwdata, prdata
//
// Front: two-stage squaring pipeline, one item per cycle into a two-entry queue while it has room.
// Back: points are stored directly until PICK_LIMIT are held, then a farthest-entry
// scan over the store picks one to replace; end of set scans once per result emitted.
// Reset clears held count, queue and pipeline valids; held entries are not cleared.
// Either side may stall on its own; the queue and output register decouple them.
module nearest_k_within_radius_select #(
	parameter int unsigned PICK_LIMIT  = 4,
	parameter int unsigned POINT_COUNT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  nkr_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output nkr_pkg::out_item_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import nkr_pkg::*;

	cfg_t cfg_q;
	logic job_valid, job_ready, q_valid, q_ready;
	job_t job_data, q_data;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_ORIGIN_X:     cfg_q.origin_x     <= pwdata[15:0];
				REG_ORIGIN_Y:     cfg_q.origin_y     <= pwdata[15:0];
				REG_RANGE_RADIUS: cfg_q.range_radius <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ORIGIN_X:     prdata = {16'd0, cfg_q.origin_x};
			REG_ORIGIN_Y:     prdata = {16'd0, cfg_q.origin_y};
			REG_RANGE_RADIUS: prdata = {16'd0, cfg_q.range_radius};
			default:          prdata = 32'd0;
		endcase
	end

	nkr_front #(.POINT_COUNT(POINT_COUNT)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_data  (job_data)
	);

	nkr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (job_valid),
		.wr_ready (job_ready),
		.wr_data  (job_data),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_data)
	);

	nkr_back #(.PICK_LIMIT(PICK_LIMIT)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.job_data  (q_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[hw/rtl/nkr_front.sv]
// Front end: distance pipeline and radius, activity and index-range classification of each item.
module nkr_front #(
	parameter int unsigned POINT_COUNT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  nkr_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  nkr_pkg::in_item_t in_data,
	output logic              job_valid,
	input  logic              job_ready,
	output nkr_pkg::job_t     job_data
);
	import nkr_pkg::*;

	logic        s1_v_q, s2_v_q;
	logic        s1_en, s2_en;
	logic [5:0]  idx_s1, idx_s2;
	logic        ok_s1, ok_s2, last_s1, last_s2;
	logic [15:0] ax_s1, ay_s1, rad_s1;
	logic [31:0] sqx_s2, sqy_s2, rad_sq_s2;
	logic [16:0] dx, dy;
	logic [15:0] ax, ay;
	logic        ok_in;
	logic [32:0] dsq;

	assign s2_en    = !s2_v_q || job_ready;
	assign s1_en    = !s1_v_q || s2_en;
	assign in_ready = s1_en;

	always_comb begin
		dx = {in_data.pos_x[15], in_data.pos_x} - {cfg.origin_x[15], cfg.origin_x};
		dy = {in_data.pos_y[15], in_data.pos_y} - {cfg.origin_y[15], cfg.origin_y};
		ax = dx[16] ? 16'(-dx) : dx[15:0];
		ay = dy[16] ? 16'(-dy) : dy[15:0];
		ok_in = in_data.active && ({3'b000, in_data.point_index} < 9'(POINT_COUNT))
			&& (cfg.range_radius != 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (s1_en) s1_v_q <= in_valid;
			if (s2_en) s2_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en) begin
			idx_s1  <= in_data.point_index;
			ok_s1   <= ok_in;
			last_s1 <= in_data.end_of_set;
			ax_s1   <= ax;
			ay_s1   <= ay;
			rad_s1  <= cfg.range_radius;
		end
		if (s2_en) begin
			idx_s2    <= idx_s1;
			ok_s2     <= ok_s1;
			last_s2   <= last_s1;
			sqx_s2    <= ax_s1 * ax_s1;
			sqy_s2    <= ay_s1 * ay_s1;
			rad_sq_s2 <= rad_s1 * rad_s1;
		end
	end

	assign dsq = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	assign job_valid      = s2_v_q;
	assign job_data.index = idx_s2;
	assign job_data.dsq   = dsq;
	assign job_data.keep  = ok_s2 && (dsq <= {1'b0, rad_sq_s2});
	assign job_data.last  = last_s2;

endmodule

[hw/rtl/nkr_queue.sv]
// Short FIFO of classified points between front and back.
module nkr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  nkr_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output nkr_pkg::job_t rd_data
);
	import nkr_pkg::*;

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

	job_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] fill_q;
	logic          push, pop;

	assign wr_ready = fill_q != NW'(QUEUE_DEPTH);
	assign rd_valid = fill_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop) fill_q <= fill_q + NW'(1);
			else if (pop && !push) fill_q <= fill_q - NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

[hw/rtl/nkr_back.sv]
// Back end: held-point store, farthest-entry search and sorted result emission.
module nkr_back #(
	parameter int unsigned PICK_LIMIT = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  nkr_pkg::job_t      job_data,
	output logic               out_valid,
	input  logic               out_ready,
	output nkr_pkg::out_item_t out_data
);
	import nkr_pkg::*;

	localparam int unsigned IW = (PICK_LIMIT > 1) ? $clog2(PICK_LIMIT) : 1;
	localparam int unsigned CW = $clog2(PICK_LIMIT + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FIND = 3'd1;
	localparam logic [2:0] ST_REPL = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_LOAD = 3'd4;
	localparam logic [2:0] ST_NONE = 3'd5;

	logic [2:0]      st_q;
	logic [CW-1:0]   count_q, rank_q;
	logic [IW-1:0]   ptr_q, far_ptr_q;
	logic [32:0]     far_dist_q, best_dist_q;
	logic [5:0]      best_idx_q;
	logic            best_v_q;
	logic [PICK_LIMIT-1:0] done_q;
	job_t            job_q;
	logic [5:0]      held_idx_q  [PICK_LIMIT];
	logic [32:0]     held_dist_q [PICK_LIMIT];
	logic            out_v_q;
	out_item_t       out_q;

	logic [5:0]  rd_idx;
	logic [32:0] rd_dist;
	logic        full, out_free, out_load, wr_en, last_rank;
	logic [IW-1:0] wr_addr;

	assign rd_idx    = held_idx_q[ptr_q];
	assign rd_dist   = held_dist_q[ptr_q];
	assign full      = count_q == CW'(PICK_LIMIT);
	assign out_free  = !out_v_q || out_ready;
	assign out_load  = ((st_q == ST_LOAD) || (st_q == ST_NONE)) && out_free;
	assign job_ready = st_q == ST_IDLE;
	assign last_rank = rank_q == count_q - CW'(1);
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = far_ptr_q;
		if (st_q == ST_IDLE && job_valid && job_data.keep && !full) begin
			wr_en   = 1'b1;
			wr_addr = count_q[IW-1:0];
		end else if (st_q == ST_REPL && job_q.dsq < far_dist_q) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			held_idx_q[wr_addr]  <= (st_q == ST_IDLE) ? job_data.index : job_q.index;
			held_dist_q[wr_addr] <= (st_q == ST_IDLE) ? job_data.dsq : job_q.dsq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			count_q     <= '0;
			rank_q      <= '0;
			ptr_q       <= '0;
			far_ptr_q   <= '0;
			far_dist_q  <= '0;
			best_dist_q <= '0;
			best_idx_q  <= '0;
			best_v_q    <= 1'b0;
			done_q      <= '0;
			job_q       <= '0;
			out_v_q     <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					ptr_q    <= '0;
					best_v_q <= 1'b0;
					done_q   <= '0;
					rank_q   <= '0;
					if (job_valid) begin
						job_q <= job_data;
						if (job_data.keep && full) begin
							st_q <= ST_FIND;
						end else if (job_data.keep) begin
							count_q <= count_q + CW'(1);
							if (job_data.last) st_q <= ST_SCAN;
						end else if (job_data.last) begin
							st_q <= (count_q == '0) ? ST_NONE : ST_SCAN;
						end
					end
				end
				ST_FIND: begin
					if (ptr_q == '0 || rd_dist > far_dist_q) begin
						far_ptr_q  <= ptr_q;
						far_dist_q <= rd_dist;
					end
					if (ptr_q == IW'(PICK_LIMIT - 1)) begin
						ptr_q <= '0;
						st_q  <= ST_REPL;
					end else begin
						ptr_q <= ptr_q + IW'(1);
					end
				end
				ST_REPL: begin
					st_q <= job_q.last ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (!done_q[ptr_q] && (!best_v_q || rd_dist < best_dist_q)) begin
						best_v_q    <= 1'b1;
						best_dist_q <= rd_dist;
						best_idx_q  <= rd_idx;
						far_ptr_q   <= ptr_q;
					end
					if (CW'(ptr_q) == count_q - CW'(1)) begin
						st_q <= ST_LOAD;
					end else begin
						ptr_q <= ptr_q + IW'(1);
					end
				end
				ST_LOAD: begin
					if (out_free) begin
						out_q.picked_index <= best_idx_q;
						out_q.distance_sq  <= best_dist_q;
						out_q.rank         <= 2'(rank_q);
						out_q.found        <= 1'b1;
						out_q.last_pick    <= last_rank;
						done_q[far_ptr_q]  <= 1'b1;
						rank_q             <= rank_q + CW'(1);
						ptr_q              <= '0;
						best_v_q           <= 1'b0;
						if (last_rank) begin
							count_q <= '0;
							st_q    <= ST_IDLE;
						end else begin
							st_q <= ST_SCAN;
						end
					end
				end
				ST_NONE: begin
					if (out_free) begin
						out_q.picked_index <= '0;
						out_q.distance_sq  <= '0;
						out_q.rank         <= '0;
						out_q.found        <= 1'b0;
						out_q.last_pick    <= 1'b1;
						st_q               <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule
